// ----- rtl/mmp_pkg.sv -----
package mmp_pkg;

  localparam int unsigned MaxDimDefault = 16;
  localparam logic [29:0] Prime = 30'd1004535809;

  localparam int unsigned ValW  = 30;
  localparam int unsigned SizeW = 5;
  localparam int unsigned ExpW  = 31;

  // register indexes on the configuration port
  localparam logic CfgMatrixSize = 1'b0;
  localparam logic CfgExponent   = 1'b1;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_READ  = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MAC,
    ST_DRAIN,
    ST_RED,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_ONE,
    SEL_MEM
  } out_sel_e;

  // matrix slots inside the shared memory
  typedef logic [2:0] slot_t;
  localparam slot_t SlotBase = 3'd0;
  localparam slot_t SlotSq0  = 3'd1;
  localparam slot_t SlotSq1  = 3'd2;
  localparam slot_t SlotRes0 = 3'd3;
  localparam slot_t SlotRes1 = 3'd4;
  localparam int unsigned NumSlots = 5;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [29:0] value;
  } cmd_t;

  typedef struct packed {
    logic [29:0] entry;
    logic        done_res;
    logic        bad_index;
  } res_t;

  // j times the prime, for the radix-16 reduction step
  function automatic logic [33:0] prime_mult(input logic [3:0] j);
    logic [33:0] m;
    m = 34'(j) * 34'(Prime);
    return m;
  endfunction

endpackage

// ----- rtl/modular_matrix_power.sv -----
// modular matrix power, modulo the prime 1004535809
// command channel: cmd_i is taken at a clock edge where start is high and busy is low.
//   write: stores cmd_i.value as base entry (row, col); read: fetches result entry.
//   both answer with one valid_o strobe in the cycle after the transfer, so
//   writes and reads may be issued back to back, one per cycle, while busy is low.
// run: busy rises in the next cycle; the block squares and multiplies matrices held in
//   one synchronous memory, one entry at a time through a single 30x30 multiplier.
//   a run does bitlength(exponent)+popcount(exponent)-1 matrix products when the exponent
//   and the size in use are both nonzero, and none otherwise. valid_o with done_res
//   marks the end; busy falls in that cycle.
// config channel: cfg_ready_o is always high; write only while no command is pending.
// bad indexes: writes are dropped, reads answer 0, bad_index is raised.
// reset: size 1, exponent 0, result matrix reads all zero; base entries are
//   undefined until written. no clearing pass is needed.
// results are strobed for one cycle only; the receiver must take them.
module modular_matrix_power import mmp_pkg::*; #(
  parameter int unsigned MaxDim = MaxDimDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  cmd_t              cmd_i,
  output logic              valid_o,
  output res_t              res_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_index_i,
  input  logic [ExpW-1:0]   cfg_data_i
);

  localparam int unsigned Cells  = MaxDim * MaxDim;
  localparam int unsigned Depth  = NumSlots * Cells;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned CW     = ($clog2(MaxDim + 1) > SizeW) ? $clog2(MaxDim + 1) : SizeW;
  localparam int unsigned LogD   = $clog2(MaxDim);
  localparam int unsigned AccW   = ((2 * ValW + LogD + 3) / 4) * 4;
  localparam int unsigned NibN   = AccW / 4;
  localparam int unsigned NibW   = $clog2(NibN);

  state_e state_q, state_d;

  logic [SizeW-1:0] size_q;
  logic [ExpW-1:0]  exp_q;
  logic [ExpW-1:0]  exp_left_q;
  logic [CW-1:0]    d_run_q, r_q, c_q, k_q, k1_q;
  slot_t            sslot_q, rslot_q, dst_q;
  logic             res_id_q, mul_done_q, op_mul_q;
  logic             rv_q, pv_q;
  logic [NibW-1:0]  nib_q;
  logic [AccW-1:0]  acc_q;
  logic [ValW-1:0]  rem_q;
  logic [2*ValW-1:0] prod_q;
  logic             out_vld_q, out_done_q, out_bad_q;
  out_sel_e         out_sel_q;

  logic [ValW-1:0]  mem_q [Depth];
  logic [ValW-1:0]  rd_a_q, rd_b_q;

  logic [CW-1:0]    d_use, dm1, row_w, col_w;
  logic             accept, bad, in_run, last_k, drained, red_last, entry_last;
  logic             start_mul, start_sq;
  slot_t            lhs_slot;
  logic [AddrW-1:0] raddr_a, raddr_b, waddr, host_addr;
  logic             we;
  logic [ValW-1:0]  wdata, lhs;
  logic [33:0]      t;
  logic [3:0]       jsel;
  logic [ValW-1:0]  rem_d;

  function automatic logic [AddrW-1:0] cell_addr(input slot_t s, input logic [CW-1:0] r,
                                                 input logic [CW-1:0] c);
    logic [AddrW-1:0] a;
    a = AddrW'(s) * AddrW'(Cells) + AddrW'(r) * AddrW'(MaxDim) + AddrW'(c);
    return a;
  endfunction

  assign cfg_ready_o = 1'b1;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  assign d_use  = (CW'(size_q) > CW'(MaxDim)) ? CW'(MaxDim) : CW'(size_q);
  assign dm1    = d_run_q - CW'(1);
  assign row_w  = CW'(cmd_i.row);
  assign col_w  = CW'(cmd_i.col);
  assign bad    = (row_w >= d_use) || (col_w >= d_use);
  assign in_run = (row_w < d_run_q) && (col_w < d_run_q);

  assign last_k     = (k_q == dm1);
  assign drained    = !rv_q && !pv_q;
  assign red_last   = (nib_q == '0);
  assign entry_last = (r_q == dm1) && (c_q == dm1);
  assign start_mul  = exp_left_q[0] && !mul_done_q;
  assign start_sq   = !start_mul && (exp_left_q[ExpW-1:1] != '0);

  assign lhs_slot  = op_mul_q ? rslot_q : sslot_q;
  assign host_addr = cell_addr(SlotBase, row_w, col_w);
  assign raddr_a   = (state_q == ST_IDLE) ? cell_addr(rslot_q, row_w, col_w)
                                          : cell_addr(lhs_slot, r_q, k_q);
  assign raddr_b   = cell_addr(sslot_q, k_q, c_q);

  // identity on the left until the first multiply lands
  assign lhs = (op_mul_q && res_id_q) ? ((k1_q == r_q) ? ValW'(1) : '0) : rd_a_q;

  // radix-16 reduction step
  assign t = {rem_q, acc_q[AccW-1 -: 4]};
  always_comb begin
    jsel = '0;
    for (int j = 1; j < 16; j++) begin
      if (t >= prime_mult(4'(j))) jsel = 4'(j);
    end
  end
  assign rem_d = ValW'(t - prime_mult(jsel));

  always_comb begin
    we    = 1'b0;
    waddr = host_addr;
    wdata = cmd_i.value;
    if (accept && cmd_i.action == ACT_WRITE && !bad) begin
      we = 1'b1;
    end else if (state_q == ST_RED && red_last) begin
      we    = 1'b1;
      waddr = cell_addr(dst_q, r_q, c_q);
      wdata = rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rd_a_q <= mem_q[raddr_a];
    rd_b_q <= mem_q[raddr_b];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && cmd_i.action == ACT_RUN) state_d = ST_STEP;
      end
      ST_STEP: begin
        if (exp_left_q == '0) state_d = ST_FIN;
        else if (start_mul || start_sq) state_d = ST_MAC;
      end
      ST_MAC: begin
        if (last_k) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) state_d = ST_RED;
      end
      ST_RED: begin
        if (red_last) state_d = entry_last ? ST_STEP : ST_MAC;
      end
      ST_FIN: begin
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      size_q     <= SizeW'(1);
      exp_q      <= '0;
      exp_left_q <= '0;
      d_run_q    <= '0;
      res_id_q   <= 1'b1;
      mul_done_q <= 1'b0;
      op_mul_q   <= 1'b0;
      sslot_q    <= SlotBase;
      rslot_q    <= SlotRes0;
      dst_q      <= SlotRes0;
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      nib_q      <= '0;
      rv_q       <= 1'b0;
      pv_q       <= 1'b0;
      out_vld_q  <= 1'b0;
      out_done_q <= 1'b0;
      out_bad_q  <= 1'b0;
      out_sel_q  <= SEL_ZERO;
    end else begin
      state_q   <= state_d;
      rv_q      <= (state_q == ST_MAC);
      pv_q      <= rv_q;
      out_vld_q <= 1'b0;

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMatrixSize: size_q <= cfg_data_i[SizeW-1:0];
          CfgExponent:   exp_q  <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            out_done_q <= 1'b0;
            out_bad_q  <= 1'b0;
            out_sel_q  <= SEL_ZERO;
            priority case (cmd_i.action)
              ACT_WRITE: begin
                out_vld_q <= 1'b1;
                out_bad_q <= bad;
              end
              ACT_READ: begin
                out_vld_q <= 1'b1;
                out_bad_q <= bad;
                if (!bad && in_run) begin
                  if (!res_id_q) out_sel_q <= SEL_MEM;
                  else if (row_w == col_w) out_sel_q <= SEL_ONE;
                end
              end
              ACT_RUN: begin
                exp_left_q <= (d_use == '0) ? '0 : exp_q;
                d_run_q    <= d_use;
                sslot_q    <= SlotBase;
                res_id_q   <= 1'b1;
                mul_done_q <= 1'b0;
              end
              default: out_vld_q <= 1'b1;
            endcase
          end
        end
        ST_STEP: begin
          r_q <= '0;
          c_q <= '0;
          k_q <= '0;
          if (exp_left_q != '0) begin
            if (start_mul) begin
              op_mul_q <= 1'b1;
              dst_q    <= (rslot_q == SlotRes0) ? SlotRes1 : SlotRes0;
            end else if (start_sq) begin
              op_mul_q <= 1'b0;
              dst_q    <= (sslot_q == SlotSq0) ? SlotSq1 : SlotSq0;
            end else begin
              exp_left_q <= '0;
            end
          end
        end
        ST_MAC: begin
          k_q <= k_q + CW'(1);
        end
        ST_DRAIN: begin
          nib_q <= NibW'(NibN - 1);
        end
        ST_RED: begin
          nib_q <= nib_q - NibW'(1);
          if (red_last) begin
            k_q <= '0;
            if (c_q == dm1) begin
              c_q <= '0;
              r_q <= r_q + CW'(1);
            end else begin
              c_q <= c_q + CW'(1);
            end
            if (entry_last) begin
              if (op_mul_q) begin
                rslot_q    <= dst_q;
                res_id_q   <= 1'b0;
                mul_done_q <= 1'b1;
              end else begin
                sslot_q    <= dst_q;
                exp_left_q <= exp_left_q >> 1;
                mul_done_q <= 1'b0;
              end
            end
          end
        end
        ST_FIN: begin
          out_vld_q  <= 1'b1;
          out_done_q <= 1'b1;
          out_bad_q  <= 1'b0;
          out_sel_q  <= SEL_ZERO;
        end
        default: ;
      endcase
    end
  end

  // multiply-accumulate datapath and reduction shifter
  always_ff @(posedge clk_i) begin
    k1_q <= k_q;
    if (rv_q) prod_q <= lhs * rd_b_q;
    if ((state_q == ST_STEP) || (state_q == ST_RED && red_last)) begin
      acc_q <= '0;
    end else if (state_q == ST_RED) begin
      acc_q <= acc_q << 4;
    end else if (pv_q) begin
      acc_q <= acc_q + AccW'(prod_q);
    end
    if (state_q == ST_DRAIN) rem_q <= '0;
    else if (state_q == ST_RED) rem_q <= rem_d;
  end

  assign valid_o         = out_vld_q;
  assign res_o.done_res  = out_done_q;
  assign res_o.bad_index = out_bad_q;
  always_comb begin
    unique case (out_sel_q)
      SEL_ONE: res_o.entry = ValW'(1);
      SEL_MEM: res_o.entry = rd_a_q;
      default: res_o.entry = '0;
    endcase
  end

endmodule

// ----- test/modular_matrix_power_tb.sv -----
module modular_matrix_power_tb;
  import mmp_pkg::*;

  localparam int unsigned Dim = 16;
  localparam longint unsigned P = 64'd1004535809;
  localparam int unsigned PLast = 32'd1004535808;
  localparam logic [1:0] ActIdle = 2'd3;  // unused code, answers all zero
  localparam int unsigned RandItems = 1150;
  localparam longint unsigned CycleLimit = 64'd8000000;

  typedef logic [29:0] mat_t [Dim*Dim];

  typedef struct {
    bit          is_cfg;
    logic        cfg_idx;
    logic [30:0] cfg_val;
    cmd_t        cmd;
    bit          has_exp;
    res_t        exp_res;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  cmd_t        cmd_i = '0;
  logic        valid_o;
  res_t        res_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [30:0] cfg_data_i = '0;

  modular_matrix_power dut (
    .clk_i, .rst_ni, .start, .busy, .cmd_i, .valid_o, .res_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // shadow state of the block
  mat_t        base_m;
  mat_t        power_m;
  bit          base_set [Dim*Dim];
  logic [4:0]  size_reg;
  logic [30:0] exp_reg;

  res_t        pending_q [$];
  row_t        dir_rows [$];
  int unsigned fail_cnt = 0;
  int unsigned sent_cnt = 0;
  longint unsigned cycles = 0;

  function automatic int unsigned dim_used();
    return (size_reg > Dim) ? Dim : int'(size_reg);
  endfunction

  function automatic void mat_mul(input mat_t a, input mat_t b, input int unsigned d,
                                  output mat_t prod);
    longint unsigned acc;
    for (int i = 0; i < Dim*Dim; i++) prod[i] = '0;
    for (int r = 0; r < d; r++) begin
      for (int c = 0; c < d; c++) begin
        acc = 0;
        for (int k = 0; k < d; k++) begin
          acc += longint'(a[r*Dim+k]) * longint'(b[k*Dim+c]);
          acc %= P;
        end
        prod[r*Dim+c] = acc[29:0];
      end
    end
  endfunction

  function automatic res_t predict_result(cmd_t c);
    res_t        r;
    int unsigned d;
    bit          bad;
    logic [30:0] e;
    mat_t        sq;
    mat_t        tmp;
    r = '0;
    d = dim_used();
    bad = (c.row >= d) || (c.col >= d);
    case (c.action)
      ACT_WRITE: begin
        if (bad) r.bad_index = 1'b1;
        else base_m[c.row*Dim+c.col] = c.value;
      end
      ACT_RUN: begin
        for (int i = 0; i < Dim*Dim; i++) power_m[i] = '0;
        for (int i = 0; i < d; i++) power_m[i*Dim+i] = 30'd1;
        sq = base_m;
        e = exp_reg;
        while (e != 0) begin
          if (e[0]) begin
            mat_mul(power_m, sq, d, tmp);
            power_m = tmp;
          end
          mat_mul(sq, sq, d, tmp);
          sq = tmp;
          e = e >> 1;
        end
        r.done_res = 1'b1;
      end
      ACT_READ: begin
        if (bad) r.bad_index = 1'b1;
        else r.entry = power_m[c.row*Dim+c.col];
      end
      default: ;
    endcase
    return r;
  endfunction

  // single command transfer, expectation queued on acceptance
  task automatic issue_cmd(cmd_t c, bit has_exp, res_t exp_res);
    res_t pred;
    @(negedge clk_i);
    start = 1'b1;
    cmd_i = c;
    do @(posedge clk_i); while (busy);
    pred = predict_result(c);
    if (c.action == ACT_WRITE && (c.row < dim_used()) && (c.col < dim_used()))
      base_set[c.row*Dim+c.col] = 1'b1;
    pending_q.push_back(has_exp ? exp_res : pred);
    sent_cnt++;
  endtask

  // a run must never see a base entry that was never written
  task automatic send_cmd(cmd_t c, bit has_exp, res_t exp_res);
    cmd_t w;
    int unsigned d;
    d = dim_used();
    if (c.action == ACT_RUN) begin
      for (int r = 0; r < d; r++) begin
        for (int k = 0; k < d; k++) begin
          if (!base_set[r*Dim+k]) begin
            w.action = ACT_WRITE;
            w.row = 4'(r);
            w.col = 4'(k);
            w.value = 30'($urandom_range(0, PLast));
            issue_cmd(w, 1'b0, '0);
          end
        end
      end
    end
    issue_cmd(c, has_exp, exp_res);
  endtask

  task automatic idle_gap();
    int unsigned n;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) n = 0;
    else if (pick < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 40);
    if (n > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending_q.size() != 0 || busy) @(posedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [30:0] val);
    drain();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgMatrixSize) size_reg = val[4:0];
    else exp_reg = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic void add_cmd(logic [1:0] act, logic [3:0] r, logic [3:0] c,
                                  logic [29:0] v, bit has_exp, res_t exp_res);
    row_t t;
    t = '{default: '0};
    t.cmd = '{action: act, row: r, col: c, value: v};
    t.has_exp = has_exp;
    t.exp_res = exp_res;
    dir_rows.push_back(t);
  endfunction

  function automatic void add_cfg(logic idx, logic [30:0] val);
    row_t t;
    t = '{default: '0};
    t.is_cfg = 1'b1;
    t.cfg_idx = idx;
    t.cfg_val = val;
    dir_rows.push_back(t);
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result transfer: entry %0d", res_o.entry);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (res_o.entry !== want.entry) begin
          $error("entry: expected %0d, got %0d", want.entry, res_o.entry);
          fail_cnt++;
        end
        if (res_o.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, res_o.done_res);
          fail_cnt++;
        end
        if (res_o.bad_index !== want.bad_index) begin
          $error("bad_index: expected %0d, got %0d", want.bad_index, res_o.bad_index);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cmd_t        c;
    int unsigned phase_len;
    int unsigned pick;
    int unsigned d;
    logic [4:0]  sz;
    logic [30:0] ex;
    bit          paused;

    for (int i = 0; i < Dim*Dim; i++) begin
      base_m[i] = '0;
      power_m[i] = '0;
      base_set[i] = 1'b0;
    end
    size_reg = 5'd1;
    exp_reg = '0;

    // reset state, bad indexes, unreduced value, zero and full exponents,
    // size zero and sizes beyond the limit, unused action
    add_cmd(ACT_READ, 4'd0, 4'd0, '0, 1'b1, '{entry: '0, done_res: 1'b0, bad_index: 1'b0});
    add_cmd(ACT_READ, 4'd15, 4'd15, '0, 1'b1, '{entry: '0, done_res: 1'b0, bad_index: 1'b1});
    add_cmd(ACT_WRITE, 4'd15, 4'd0, 30'h3FFFFFFF, 1'b1,
            '{entry: '0, done_res: 1'b0, bad_index: 1'b1});
    add_cmd(ACT_WRITE, 4'd0, 4'd0, 30'h3FFFFFFF, 1'b0, '0);
    add_cmd(ACT_RUN, 4'd0, 4'd0, '0, 1'b1, '{entry: '0, done_res: 1'b1, bad_index: 1'b0});
    add_cmd(ACT_READ, 4'd0, 4'd0, '0, 1'b1, '{entry: 30'd1, done_res: 1'b0, bad_index: 1'b0});
    add_cmd(ActIdle, 4'd15, 4'd15, 30'h3FFFFFFF, 1'b1, '0);
    add_cfg(CfgExponent, 31'd1);
    add_cmd(ACT_RUN, 4'd0, 4'd0, '0, 1'b0, '0);
    add_cmd(ACT_READ, 4'd0, 4'd0, '0, 1'b0, '0);
    add_cfg(CfgMatrixSize, 31'd2);
    add_cmd(ACT_WRITE, 4'd0, 4'd1, 30'd1004535808, 1'b0, '0);
    add_cmd(ACT_WRITE, 4'd1, 4'd0, 30'd1, 1'b0, '0);
    add_cmd(ACT_WRITE, 4'd1, 4'd1, 30'd12345, 1'b0, '0);
    add_cfg(CfgExponent, 31'h7FFFFFFF);
    add_cmd(ACT_RUN, 4'd0, 4'd0, '0, 1'b0, '0);
    add_cmd(ACT_READ, 4'd1, 4'd1, '0, 1'b0, '0);
    add_cmd(ACT_READ, 4'd0, 4'd1, '0, 1'b0, '0);
    add_cmd(ACT_READ, 4'd2, 4'd1, '0, 1'b1, '{entry: '0, done_res: 1'b0, bad_index: 1'b1});
    add_cfg(CfgMatrixSize, 31'd0);
    add_cmd(ACT_WRITE, 4'd0, 4'd0, 30'd7, 1'b1, '{entry: '0, done_res: 1'b0, bad_index: 1'b1});
    add_cmd(ACT_RUN, 4'd0, 4'd0, '0, 1'b1, '{entry: '0, done_res: 1'b1, bad_index: 1'b0});
    add_cmd(ACT_READ, 4'd0, 4'd0, '0, 1'b1, '{entry: '0, done_res: 1'b0, bad_index: 1'b1});
    add_cfg(CfgMatrixSize, 31'd31);
    add_cfg(CfgExponent, 31'd3);
    add_cmd(ACT_RUN, 4'd0, 4'd0, '0, 1'b0, '0);
    add_cmd(ACT_READ, 4'd15, 4'd15, '0, 1'b0, '0);
    add_cfg(CfgMatrixSize, 31'd17);
    add_cmd(ACT_READ, 4'd15, 4'd0, '0, 1'b0, '0);

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      else send_cmd(dir_rows[i].cmd, dir_rows[i].has_exp, dir_rows[i].exp_res);
    end

    paused = 1'b0;
    while (sent_cnt < RandItems) begin
      // new setting per phase; large sizes only with short exponents
      pick = $urandom_range(0, 99);
      if (pick < 70) sz = 5'($urandom_range(1, 4));
      else if (pick < 88) sz = 5'($urandom_range(5, 8));
      else sz = 5'($urandom_range(9, 31));
      if (pick < 3) sz = 5'd0;
      write_reg(CfgMatrixSize, {26'd0, sz});
      d = dim_used();
      pick = $urandom_range(0, 99);
      if (pick < 70) ex = 31'($urandom_range(0, 20));
      else if (pick < 90) ex = 31'($urandom_range(0, 65535));
      else ex = 31'($urandom() & 32'h7FFFFFFF);
      if (d > 8) ex = ex & 31'd7;
      else if (d > 4) ex = ex & 31'h3FF;
      write_reg(CfgExponent, ex);

      phase_len = $urandom_range(30, 80);
      for (int n = 0; n < phase_len && sent_cnt < RandItems; n++) begin
        pick = $urandom_range(0, 99);
        c.value = ($urandom_range(0, 9) == 0) ? 30'($urandom())
                                               : 30'($urandom_range(0, PLast));
        if (pick < 80 && d > 0) begin
          c.row = 4'($urandom_range(0, d - 1));
          c.col = 4'($urandom_range(0, d - 1));
        end else begin
          c.row = 4'($urandom());
          c.col = 4'($urandom());
        end
        pick = $urandom_range(0, 99);
        if (pick < 45) c.action = ACT_WRITE;
        else if (pick < 90) c.action = ACT_READ;
        else if (pick < 96) c.action = ACT_RUN;
        else c.action = ActIdle;
        send_cmd(c, 1'b0, '0);
        idle_gap();
        if (!paused && sent_cnt > RandItems / 2) begin
          paused = 1'b1;
          drain();
        end
      end
    end

    @(negedge clk_i);
    start = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // more than 1000 outstanding expectations count as a failure
  always @(posedge clk_i) begin
    if (rst_ni && pending_q.size() > 1000) begin
      $error("result store overflow");
      fail_cnt++;
    end
  end

endmodule

// ----- files.f -----
rtl/mmp_pkg.sv
rtl/modular_matrix_power.sv
test/modular_matrix_power_tb.sv
